### hw/rtl/qct_pkg.sv
`default_nettype none

package qct_pkg;

	localparam int MAX_TERMS_DEF = 256;
	localparam int MAX_VARS_DEF  = 1024;

	localparam int OPCODE_W  = 3;
	localparam int VAR_W     = 10;
	localparam int COEFF_W   = 32;
	localparam int VALUE_W   = 48;
	localparam int VCOUNT_W  = 11;
	localparam int TCOUNT_W  = 9;

	// operation codes
	localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_READ   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SETBIT = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_EVAL   = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_CLEAN  = 3'd6;

	// one stored term: normalized pair and its coefficient
	typedef struct packed {
		logic [VAR_W-1:0]          lo;
		logic [VAR_W-1:0]          hi;
		logic signed [COEFF_W-1:0] coeff;
	} entry_t;

	// off-diagonal term with a positive coefficient
	function automatic logic cross_pos(input logic [VAR_W-1:0] lo, input logic [VAR_W-1:0] hi,
		input logic signed [COEFF_W-1:0] c);
		return (lo != hi) && !c[COEFF_W-1] && (c != '0);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/qct_entry_mem.sv
`default_nettype none

module qct_entry_mem #(
	parameter int MAX_TERMS = qct_pkg::MAX_TERMS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(MAX_TERMS)-1:0] waddr,
	input  wire qct_pkg::entry_t              wdata,
	input  wire logic [$clog2(MAX_TERMS)-1:0] raddr,
	output qct_pkg::entry_t                   rdata
);
	import qct_pkg::*;

	entry_t mem [MAX_TERMS];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/qct_assign_mem.sv
`default_nettype none

module qct_assign_mem #(
	parameter int MAX_VARS = qct_pkg::MAX_VARS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        we,
	input  wire logic [$clog2(MAX_VARS)-1:0] waddr,
	input  wire logic                        wdata,
	input  wire logic [$clog2(MAX_VARS)-1:0] raddr_a,
	input  wire logic [$clog2(MAX_VARS)-1:0] raddr_b,
	output logic                             rdata_a,
	output logic                             rdata_b,
	output logic                             busy
);
	import qct_pkg::*;

	localparam int AW = $clog2(MAX_VARS);

	logic          mem [MAX_VARS];
	logic [AW-1:0] clr_idx_q;
	logic          clr_busy_q;

	assign busy = clr_busy_q;

	// clearing pass after reset, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(MAX_VARS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write port shared by the clearing pass and set bit
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= 1'b0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### hw/rtl/qct_adder.sv
`default_nettype none

module qct_adder #(
	parameter int ACC_W = 41
) (
	input  wire logic signed [ACC_W-1:0]            a,
	input  wire logic signed [qct_pkg::COEFF_W-1:0] b,
	output logic signed [ACC_W-1:0]                 sum,
	output logic signed [qct_pkg::COEFF_W-1:0]      sat32
);
	import qct_pkg::*;

	logic ovf;

	// exact sum for accumulation
	assign sum = a + ACC_W'(b);

	// clamp to the coefficient range: overflow when the upper bits disagree
	assign ovf   = !((&sum[ACC_W-1:COEFF_W-1]) || !(|sum[ACC_W-1:COEFF_W-1]));
	assign sat32 = ovf ? (sum[ACC_W-1] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}})
		: sum[COEFF_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/quadratic_coefficient_table.sv
`default_nettype none
// add, read, delete, evaluate and clean scan every slot of the entry memory
// clear and set bit skip the scan; an unused opcode skips the commit as well
// throughput: one word at a time, the next taken the cycle after a result is loaded into a
// free output register; the scan of the entry memory, one slot per cycle, sets it
// reset: table empty, counters zero; then a clearing pass over all MAX_VARS
// assignment bits during which no word is taken

module quadratic_coefficient_table #(
	parameter int MAX_TERMS = qct_pkg::MAX_TERMS_DEF,
	parameter int MAX_VARS  = qct_pkg::MAX_VARS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [qct_pkg::OPCODE_W-1:0]         opcode,
	input  wire logic [qct_pkg::VAR_W-1:0]            var_first,
	input  wire logic [qct_pkg::VAR_W-1:0]            var_second,
	input  wire logic signed [qct_pkg::COEFF_W-1:0]   coeff_in,
	input  wire logic                                 bit_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [qct_pkg::VALUE_W-1:0]        value_out,
	output logic                                      found,
	output logic                                      submodular,
	output logic [qct_pkg::VCOUNT_W-1:0]              var_count,
	output logic [qct_pkg::TCOUNT_W-1:0]              term_count,
	output logic                                      table_full
);
	import qct_pkg::*;

	localparam int TW    = $clog2(MAX_TERMS);
	localparam int CW    = $clog2(MAX_TERMS + 1);
	localparam int AW    = $clog2(MAX_VARS);
	localparam int ACC_W = COEFF_W + TW + 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]                state_q;
	logic [OPCODE_W-1:0]       op_q;
	logic [VAR_W-1:0]          lo_q, hi_q, a_q;
	logic signed [COEFF_W-1:0] cin_q;
	logic                      bit_q;

	logic [CW-1:0]             cnt_q;
	logic                      iss_s1, vld_s1;
	logic [TW-1:0]             idx_s1;
	logic                      iss_s2, use_s2, inr_s2;
	logic signed [COEFF_W-1:0] coeff_s2;

	logic                      hit_q, free_q;
	logic [TW-1:0]             slot_q, fslot_q;
	logic signed [COEFF_W-1:0] hcoeff_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic [MAX_TERMS-1:0]      valid_q;
	logic [CW-1:0]             stored_q, pcc_q;
	logic [VCOUNT_W-1:0]       hv_q;

	logic signed [VALUE_W-1:0] res_value_q;
	logic                      res_found_q, res_full_q;
	logic                      out_valid_q;

	entry_t                    ent_rd, ent_wr;
	logic                      ent_we;
	logic [TW-1:0]             ent_waddr;
	logic                      bit_a, bit_b, asg_busy, asg_we;

	logic                      accept, issue, scan_done, out_free;
	logic [VAR_W-1:0]          in_lo, in_hi;
	logic signed [ACC_W-1:0]   add_a, add_sum;
	logic signed [COEFF_W-1:0] add_b, add_sat;
	logic                      lo_inr, hi_inr;

	// handshake
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || asg_busy;
	assign out_free = !out_valid_q || !out_stall;

	// pair normalization
	assign in_lo = (var_first < var_second) ? var_first : var_second;
	assign in_hi = (var_first < var_second) ? var_second : var_first;

	// scan control
	assign issue     = (state_q == ST_SCAN) && (cnt_q < CW'(MAX_TERMS));
	assign scan_done = (cnt_q == CW'(MAX_TERMS)) && !iss_s1 && !iss_s2;

	// range checks for the assignment lookup
	assign lo_inr = int'(ent_rd.lo) < MAX_VARS;
	assign hi_inr = int'(ent_rd.hi) < MAX_VARS;

	qct_entry_mem #(.MAX_TERMS(MAX_TERMS)) u_entry (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wr),
		.raddr (cnt_q[TW-1:0]),
		.rdata (ent_rd)
	);

	assign asg_we = (state_q == ST_COMMIT) && (op_q == OP_SETBIT) && (int'(a_q) < MAX_VARS);

	qct_assign_mem #(.MAX_VARS(MAX_VARS)) u_assign (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (asg_we),
		.waddr   (AW'(a_q)),
		.wdata   (bit_q),
		.raddr_a (AW'(ent_rd.lo)),
		.raddr_b (AW'(ent_rd.hi)),
		.rdata_a (bit_a),
		.rdata_b (bit_b),
		.busy    (asg_busy)
	);

	// shared adder: accumulation while scanning, saturating add on commit
	assign add_a = (state_q == ST_SCAN) ? acc_q : ACC_W'(hcoeff_q);
	assign add_b = (state_q == ST_SCAN) ? coeff_s2 : cin_q;

	qct_adder #(.ACC_W(ACC_W)) u_adder (
		.a     (add_a),
		.b     (add_b),
		.sum   (add_sum),
		.sat32 (add_sat)
	);

	// entry write on commit of an add
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = slot_q;
		ent_wr    = '{lo: lo_q, hi: hi_q, coeff: cin_q};
		if (state_q == ST_COMMIT && op_q == OP_ADD) begin
			if (hit_q) begin
				ent_we       = 1'b1;
				ent_wr.coeff = add_sat;
			end else if (free_q) begin
				ent_we    = 1'b1;
				ent_waddr = fslot_q;
			end
		end
	end

	// scan pipeline payload
	always_ff @(posedge clk) begin
		idx_s1   <= cnt_q[TW-1:0];
		coeff_s2 <= ent_rd.coeff;
		inr_s2   <= lo_inr && hi_inr;
		use_s2   <= iss_s1 && vld_s1;
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_ADD;
			cnt_q    <= '0;
			iss_s1   <= 1'b0;
			vld_s1   <= 1'b0;
			iss_s2   <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			slot_q   <= '0;
			fslot_q  <= '0;
			hcoeff_q <= '0;
			acc_q    <= '0;
			valid_q  <= '0;
			stored_q <= '0;
			pcc_q    <= '0;
			hv_q     <= '0;
		end else begin
			iss_s1 <= issue;
			vld_s1 <= valid_q[cnt_q[TW-1:0]];
			iss_s2 <= iss_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= opcode;
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						acc_q  <= '0;
						if (opcode == OP_ADD && VCOUNT_W'(in_hi) + 1'b1 > hv_q) begin
							hv_q <= VCOUNT_W'(in_hi) + 1'b1;
						end
						case (opcode) inside
							OP_ADD, OP_READ, OP_DELETE, OP_EVAL, OP_CLEAN: state_q <= ST_SCAN;
							OP_CLEAR, OP_SETBIT: state_q <= ST_COMMIT;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// lookup and lowest free slot
					if (iss_s1 && vld_s1 && ent_rd.lo == lo_q && ent_rd.hi == hi_q) begin
						hit_q    <= 1'b1;
						slot_q   <= idx_s1;
						hcoeff_q <= ent_rd.coeff;
					end
					if (iss_s1 && !vld_s1 && !free_q) begin
						free_q  <= 1'b1;
						fslot_q <= idx_s1;
					end
					// clean drops zero terms in passing
					if (op_q == OP_CLEAN && iss_s1 && vld_s1 && ent_rd.coeff == '0) begin
						valid_q[idx_s1] <= 1'b0;
						stored_q        <= stored_q - 1'b1;
					end
					// evaluate accumulates terms whose variables are both set
					if (op_q == OP_EVAL && iss_s2 && use_s2 && inr_s2 && bit_a && bit_b) begin
						acc_q <= add_sum;
					end
					if (scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_DONE;
					case (op_q)
						OP_ADD: begin
							if (hit_q) begin
								pcc_q <= pcc_q - CW'(cross_pos(lo_q, hi_q, hcoeff_q))
									+ CW'(cross_pos(lo_q, hi_q, add_sat));
							end else if (free_q) begin
								valid_q[fslot_q] <= 1'b1;
								stored_q         <= stored_q + 1'b1;
								pcc_q            <= pcc_q + CW'(cross_pos(lo_q, hi_q, cin_q));
							end
						end
						OP_DELETE: begin
							if (hit_q) begin
								valid_q[slot_q] <= 1'b0;
								stored_q        <= stored_q - 1'b1;
								pcc_q           <= pcc_q - CW'(cross_pos(lo_q, hi_q, hcoeff_q));
							end
						end
						OP_CLEAR: begin
							valid_q  <= '0;
							stored_q <= '0;
							pcc_q    <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// captured operands and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q  <= in_lo;
			hi_q  <= in_hi;
			a_q   <= var_first;
			cin_q <= coeff_in;
			bit_q <= bit_value;
		end
		if (state_q == ST_IDLE) begin
			res_value_q <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else if (state_q == ST_COMMIT) begin
			res_found_q <= hit_q && (op_q == OP_READ || op_q == OP_DELETE);
			res_full_q  <= (op_q == OP_ADD) && !hit_q && !free_q;
			if (op_q == OP_READ && hit_q) begin
				res_value_q <= VALUE_W'(hcoeff_q);
			end else if (op_q == OP_EVAL) begin
				// the exact sum of at most MAX_TERMS coefficients fits the result width
				res_value_q <= VALUE_W'(acc_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			value_out  <= res_value_q;
			found      <= res_found_q;
			table_full <= res_full_q;
			submodular <= (pcc_q == '0);
			var_count  <= hv_q;
			term_count <= TCOUNT_W'(stored_q);
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_pcc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcc_q <= stored_q) else $error("positive cross count exceeds stored terms");

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(MAX_TERMS)) else $error("stored term count beyond capacity");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> state_q == ST_DONE)
		else $error("result left while output register was held");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(iss_s1 || iss_s2) |-> state_q == ST_SCAN) else $error("scan pipeline busy outside scan");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import qct_pkg::*;

	localparam int MAX_TERMS = MAX_TERMS_DEF;
	localparam int MAX_VARS  = MAX_VARS_DEF;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
	localparam longint COEFF_MAX = 64'sd2147483647;
	localparam longint COEFF_MIN = -64'sd2147483648;
	localparam longint SUM_MAX = (64'sd1 <<< (VALUE_W - 1)) - 1;
	localparam longint SUM_MIN = -(64'sd1 <<< (VALUE_W - 1));
	localparam int HOLD_AFTER = 1000;
	localparam int HOLD_SPAN = 700;

	typedef struct {
		logic [OPCODE_W-1:0]       op;
		logic [VAR_W-1:0]          va;
		logic [VAR_W-1:0]          vb;
		logic signed [COEFF_W-1:0] coeff;
		logic                      bitv;
		bit                        drain_first;
	} table_word_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      found;
		logic                      submod;
		logic [VCOUNT_W-1:0]       vcount;
		logic [TCOUNT_W-1:0]       tcount;
		logic                      full;
	} table_report_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [VAR_W-1:0] var_first = '0;
	logic [VAR_W-1:0] var_second = '0;
	logic signed [COEFF_W-1:0] coeff_in = '0;
	logic bit_value = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VALUE_W-1:0] value_out;
	logic found;
	logic submodular;
	logic [VCOUNT_W-1:0] var_count;
	logic [TCOUNT_W-1:0] term_count;
	logic table_full;

	quadratic_coefficient_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.var_first(var_first),
		.var_second(var_second),
		.coeff_in(coeff_in),
		.bit_value(bit_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_out(value_out),
		.found(found),
		.submodular(submodular),
		.var_count(var_count),
		.term_count(term_count),
		.table_full(table_full)
	);

	// shadow copy of the coefficient table
	bit slot_used [MAX_TERMS];
	logic [VAR_W-1:0] slot_lo [MAX_TERMS];
	logic [VAR_W-1:0] slot_hi [MAX_TERMS];
	logic signed [COEFF_W-1:0] slot_coeff [MAX_TERMS];
	bit assign_bit [MAX_VARS];
	int highest_var = 0;
	int positive_cross = 0;
	int stored_terms = 0;
	int op_tally [8];
	int dropped_adds = 0;

	table_word_t pending [$];
	table_report_t due_reports [$];
	table_word_t cur_word;
	table_word_t head_word;
	bit drain_next = 1'b0;
	int accepted_count = 0;
	int result_count = 0;
	int fail_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_fired = 1'b0;

	function automatic bit positive_cross_term(input logic [VAR_W-1:0] lo,
		input logic [VAR_W-1:0] hi, input logic signed [COEFF_W-1:0] c);
		return (lo != hi) && (c > 0);
	endfunction

	function automatic void drop_slot(input int i);
		if (positive_cross_term(slot_lo[i], slot_hi[i], slot_coeff[i]))
			positive_cross--;
		slot_used[i] = 1'b0;
		stored_terms--;
	endfunction

	// apply one word to the shadow table and return the status it reports
	function automatic table_report_t apply_word(input table_word_t w);
		table_report_t r;
		logic [VAR_W-1:0] lo;
		logic [VAR_W-1:0] hi;
		int hit;
		int free_slot;
		longint acc;
		lo = (w.va < w.vb) ? w.va : w.vb;
		hi = (w.va < w.vb) ? w.vb : w.va;
		hit = -1;
		free_slot = -1;
		acc = 0;
		r.value = '0;
		r.found = 1'b0;
		r.full = 1'b0;
		op_tally[w.op]++;
		for (int i = MAX_TERMS - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_lo[i] == lo && slot_hi[i] == hi)
				hit = i;
			if (!slot_used[i])
				free_slot = i;
		end
		case (w.op)
			OP_ADD: begin
				if (int'(hi) + 1 > highest_var)
					highest_var = int'(hi) + 1;
				if (hit >= 0) begin
					acc = longint'(slot_coeff[hit]) + longint'(w.coeff);
					if (acc > COEFF_MAX)
						acc = COEFF_MAX;
					if (acc < COEFF_MIN)
						acc = COEFF_MIN;
					if (positive_cross_term(lo, hi, slot_coeff[hit]))
						positive_cross--;
					slot_coeff[hit] = acc[COEFF_W-1:0];
					if (positive_cross_term(lo, hi, slot_coeff[hit]))
						positive_cross++;
				end else if (free_slot >= 0) begin
					slot_used[free_slot] = 1'b1;
					slot_lo[free_slot] = lo;
					slot_hi[free_slot] = hi;
					slot_coeff[free_slot] = w.coeff;
					stored_terms++;
					if (positive_cross_term(lo, hi, w.coeff))
						positive_cross++;
				end else begin
					r.full = 1'b1;
					dropped_adds++;
				end
			end
			OP_READ: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.value = slot_coeff[hit];
				end
			end
			OP_DELETE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					drop_slot(hit);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < MAX_TERMS; i++)
					slot_used[i] = 1'b0;
				stored_terms = 0;
				positive_cross = 0;
			end
			OP_SETBIT: begin
				assign_bit[w.va] = w.bitv;
			end
			OP_EVAL: begin
				for (int i = 0; i < MAX_TERMS; i++)
					if (slot_used[i] && assign_bit[slot_lo[i]] && assign_bit[slot_hi[i]])
						acc += longint'(slot_coeff[i]);
				if (acc > SUM_MAX)
					acc = SUM_MAX;
				if (acc < SUM_MIN)
					acc = SUM_MIN;
				r.value = acc[VALUE_W-1:0];
			end
			OP_CLEAN: begin
				for (int i = 0; i < MAX_TERMS; i++)
					if (slot_used[i] && slot_coeff[i] == 0)
						drop_slot(i);
			end
			default: begin
			end
		endcase
		r.submod = (positive_cross == 0);
		r.vcount = highest_var[VCOUNT_W-1:0];
		r.tcount = stored_terms[TCOUNT_W-1:0];
		return r;
	endfunction

	function automatic string report_text(input table_report_t r);
		return $sformatf("value %h found %b submodular %b vars %0d terms %0d full %b",
			r.value, r.found, r.submod, r.vcount, r.tcount, r.full);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	// idle length: mostly none or short, a few long; none at all in calm windows
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (((accepted_count / 250) % 4) == 1)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	task automatic queue_word(input logic [OPCODE_W-1:0] op, input logic [VAR_W-1:0] a,
		input logic [VAR_W-1:0] b, input logic signed [COEFF_W-1:0] c, input logic bv);
		table_word_t w;
		w.op = op;
		w.va = a;
		w.vb = b;
		w.coeff = c;
		w.bitv = bv;
		w.drain_first = drain_next;
		drain_next = 1'b0;
		pending.push_back(w);
	endtask

	// variables mostly from a small pool so that pairs repeat
	function automatic logic [VAR_W-1:0] pick_var();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 11);
		if (r < 80) begin
			case ($urandom_range(0, 3))
				0: return 0;
				1: return 511;
				2: return 512;
				default: return 1023;
			endcase
		end
		return $urandom_range(0, 1023);
	endfunction

	// coefficients: zeros and small steps so terms cancel, plus extremes and noise
	function automatic logic signed [COEFF_W-1:0] pick_coeff();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 0;
		if (r < 50)
			return (int'($urandom_range(0, 6)) - 3) <<< 16;
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 1;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sender: presents queued words with random gaps, holds them while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				due_reports.push_back(apply_word(cur_word));
				accepted_count <= accepted_count + 1;
			end
			if (pending.size() != 0)
				head_word = pending[0];
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() != 0 &&
					!(head_word.drain_first && due_reports.size() != 0)) begin
				cur_word = pending.pop_front();
				opcode <= cur_word.op;
				var_first <= cur_word.va;
				var_second <= cur_word.vb;
				coeff_in <= cur_word.coeff;
				bit_value <= cur_word.bitv;
				in_valid <= 1'b1;
				gap_left <= idle_span();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall: random spans, and one long hold-off that backs up the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_fired <= 1'b0;
		end else if (!hold_fired && accepted_count >= HOLD_AFTER) begin
			hold_fired <= 1'b1;
			hold_left <= HOLD_SPAN;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= idle_span();
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result word with the oldest pending report
	always @(posedge clk) begin
		table_report_t got;
		table_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.value = value_out;
			got.found = found;
			got.submod = submodular;
			got.vcount = var_count;
			got.tcount = term_count;
			got.full = table_full;
			if (due_reports.size() == 0) begin
				note_failure($sformatf("unexpected result word: %s", report_text(got)));
			end else begin
				want = due_reports.pop_front();
				if (got.value !== want.value || got.found !== want.found ||
						got.submod !== want.submod || got.vcount !== want.vcount ||
						got.tcount !== want.tcount || got.full !== want.full)
					note_failure($sformatf("result %0d mismatch: expected %s, got %s",
						result_count, report_text(want), report_text(got)));
			end
			result_count++;
		end
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int phase_no;
		int n;
		int r;
		int j;
		logic [VAR_W-1:0] a;

		// directed: absent read, saturation both ways, zero terms, clean, delete twice
		queue_word(OP_READ, 0, 0, 0, 0);
		queue_word(OP_ADD, 5, 3, 32'sh7FFFFFFF, 0);
		queue_word(OP_ADD, 3, 5, 1, 1);
		queue_word(OP_READ, 5, 3, 0, 0);
		queue_word(OP_ADD, 7, 7, 32'sh80000000, 0);
		queue_word(OP_ADD, 7, 7, -1, 0);
		queue_word(OP_ADD, 1023, 0, 0, 0);
		queue_word(OP_ADD, 2, 9, 32'sh00010000, 0);
		queue_word(OP_ADD, 9, 2, -32'sh00010000, 0);
		queue_word(OP_SETBIT, 3, 0, 0, 1);
		queue_word(OP_SETBIT, 5, 0, 0, 1);
		queue_word(OP_SETBIT, 7, 0, 0, 1);
		queue_word(OP_SETBIT, 0, 0, 0, 1);
		queue_word(OP_SETBIT, 1023, 0, 0, 1);
		queue_word(OP_EVAL, 0, 0, 0, 0);
		queue_word(OP_CLEAN, 0, 0, 0, 0);
		queue_word(OP_READ, 2, 9, 0, 0);
		queue_word(OP_DELETE, 5, 3, 0, 0);
		queue_word(OP_DELETE, 3, 5, 0, 0);
		queue_word(OP_UNUSED, 1023, 1023, 32'shFFFFFFFF, 1);
		queue_word(OP_SETBIT, 1023, 1023, 32'shFFFFFFFF, 0);
		queue_word(OP_CLEAR, 0, 0, 0, 0);
		queue_word(OP_EVAL, 0, 0, 0, 0);
		queue_word(OP_ADD, 5, 3, 32'sh00018000, 0);
		queue_word(OP_EVAL, 0, 0, 0, 0);

		// random phases: mostly mixed traffic on a small variable pool, two table fills
		phase_no = 0;
		while (pending.size() < 2000) begin
			if (phase_no == 0 || $urandom_range(0, 19) == 0)
				drain_next = 1'b1;
			if (phase_no == 2 || phase_no == 18) begin
				queue_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
				for (int k = 0; k < MAX_TERMS + 8; k++) begin
					if (k > 8 && $urandom_range(0, 9) == 0) begin
						j = $urandom_range(0, k - 1);
						queue_word(OP_ADD, 1023 - j, j, pick_coeff(), $urandom);
					end
					if ($urandom_range(0, 1))
						queue_word(OP_ADD, k, 1023 - k, pick_coeff(), $urandom);
					else
						queue_word(OP_ADD, 1023 - k, k, pick_coeff(), $urandom);
				end
				for (int k = 0; k < 8; k++) begin
					a = $urandom_range(0, MAX_TERMS + 7);
					queue_word(OP_SETBIT, (k < 6) ? a : 1023 - a, $urandom, $urandom, 1);
				end
				queue_word(OP_EVAL, $urandom, $urandom, $urandom, $urandom);
				j = $urandom_range(0, MAX_TERMS - 1);
				queue_word(OP_READ, j, 1023 - j, $urandom, $urandom);
				queue_word(OP_DELETE, 1023 - j, j, $urandom, $urandom);
				queue_word(OP_ADD, 300, 301, pick_coeff(), $urandom);
				queue_word(OP_ADD, 302, 303, pick_coeff(), $urandom);
				queue_word(OP_EVAL, $urandom, $urandom, $urandom, $urandom);
				queue_word(OP_CLEAN, $urandom, $urandom, $urandom, $urandom);
				queue_word(OP_EVAL, $urandom, $urandom, $urandom, $urandom);
				queue_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
			end else begin
				n = $urandom_range(20, 60);
				for (int k = 0; k < n; k++) begin
					r = $urandom_range(0, 99);
					a = pick_var();
					if (r < 34)
						queue_word(OP_ADD, a, ($urandom_range(0, 4) == 0) ? a : pick_var(),
							pick_coeff(), $urandom);
					else if (r < 48)
						queue_word(OP_READ, a, ($urandom_range(0, 4) == 0) ? a : pick_var(),
							$urandom, $urandom);
					else if (r < 58)
						queue_word(OP_DELETE, a, ($urandom_range(0, 4) == 0) ? a : pick_var(),
							$urandom, $urandom);
					else if (r < 73)
						queue_word(OP_SETBIT, a, $urandom, $urandom, $urandom);
					else if (r < 85)
						queue_word(OP_EVAL, $urandom, $urandom, $urandom, $urandom);
					else if (r < 92)
						queue_word(OP_CLEAN, $urandom, $urandom, $urandom, $urandom);
					else if (r < 95)
						queue_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
					else
						queue_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
				end
			end
			phase_no++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all words taken, all reports back, then a scan's worth of quiet
		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (MAX_TERMS + 40) @(posedge clk);
		if (due_reports.size() != 0)
			note_failure($sformatf("%0d reports never arrived", due_reports.size()));

		$display("ran %0d words: %0d adds, %0d reads, %0d deletes, %0d evaluates, %0d cleans",
			accepted_count, op_tally[OP_ADD], op_tally[OP_READ], op_tally[OP_DELETE],
			op_tally[OP_EVAL], op_tally[OP_CLEAN]);
		$display("%0d clears, %0d bit writes, %0d unused codes, %0d adds dropped on a full table",
			op_tally[OP_CLEAR], op_tally[OP_SETBIT], op_tally[OP_UNUSED], dropped_adds);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d failures", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/qct_pkg.sv
hw/rtl/qct_entry_mem.sv
hw/rtl/qct_assign_mem.sv
hw/rtl/qct_adder.sv
hw/rtl/quadratic_coefficient_table.sv
sim/tb.sv
